// File: sv/utf8_codepoint_substring_locator_assert.svh
// Assertion macros for the UTF-8 codepoint substring locator.
// Used inside modules that have clk_i and rst_ni in scope; no other dependencies.
`ifndef UTF8_CODEPOINT_SUBSTRING_LOCATOR_ASSERT_SVH
`define UTF8_CODEPOINT_SUBSTRING_LOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UCSL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define UCSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: sv/ucsl_pkg.sv
// Package for the UTF-8 codepoint substring locator: types, sizes and helpers.
// No dependencies; used by the output channel interface and the top level.
package ucsl_pkg;

  // Byte counters wrap modulo this size; it must be a power of two.
  localparam int unsigned MAX_STRING_BYTES = 65536;
  localparam int unsigned POS_W            = $clog2(MAX_STRING_BYTES);
  localparam int unsigned OUT_W            = 16;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [OUT_W-1:0] out_len_t;

  typedef enum logic [1:0] {
    PH_DONE = 2'd0,
    PH_SKIP = 2'd1,
    PH_TAKE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_EMPTY  = 2'd0,
    KIND_TO_END = 2'd1,
    KIND_RANGE  = 2'd2
  } result_kind_e;

  // Brings a byte counter to the 16-bit output width: truncate or zero-extend.
  function automatic out_len_t to_out(input pos_t v);
    logic [POS_W+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, v};
    return w[OUT_W-1:0];
  endfunction

endpackage

// File: sv/ucsl_if.sv
// Valid/ready channel interfaces for the UTF-8 codepoint substring locator.
// Depends on ucsl_pkg for the output field widths.
interface ucsl_in_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  string_byte;
  logic               first_of_string;
  logic signed [31:0] start_index;
  logic signed [31:0] codepoint_count;

  modport source (output valid, string_byte, first_of_string, start_index,
                  codepoint_count, input ready);
  modport sink   (input valid, string_byte, first_of_string, start_index,
                  codepoint_count, output ready);
endinterface

interface ucsl_out_if;
  import ucsl_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  out_len_t   byte_offset;
  out_len_t   byte_length;

  modport source (output valid, result_kind, byte_offset, byte_length, input ready);
  modport sink   (input valid, result_kind, byte_offset, byte_length, output ready);
endinterface

// File: sv/utf8_codepoint_substring_locator.sv
// Top level of the UTF-8 codepoint substring locator.
// Depends on ucsl_pkg, the channel interfaces in ucsl_if.sv and the assertion header.

// Takes one string byte per item and gives one result per string: empty, offset to
// string end, or offset and length in bytes. The first item of a string carries the
// codepoint start and count. The block accepts one item every cycle unless held off;
// an item enters an input register and is decoded from there into the result
// register, where the result stays until it is taken. Input is held off only
// while the result register is full and not taken. Byte offsets wrap modulo
// MAX_STRING_BYTES.
module utf8_codepoint_substring_locator (
  input  logic       clk_i,
  input  logic       rst_ni,
  ucsl_in_if.sink    in_i,
  ucsl_out_if.source out_o
);
  import ucsl_pkg::*;

  // Input register.
  logic               in_valid_q;
  logic        [7:0]  byte_q;
  logic               first_q;
  logic signed [31:0] start_q;
  logic signed [31:0] count_q;

  // Decoder state.
  phase_e      phase_q, phase_d;
  logic [31:0] left_q, left_d;
  logic [31:0] take_q, take_d;
  pos_t        pos_q, pos_d;
  pos_t        beg_q, beg_d;
  logic [1:0]  pend_q, pend_d;
  logic        nz_q, nz_d;

  // Result register.
  logic         out_valid_q;
  result_kind_e kind_q, kind_d;
  out_len_t     off_q, off_d;
  out_len_t     len_q, len_d;

  logic out_free;
  logic process;
  logic emit;

  assign out_free   = !out_valid_q || out_o.ready;
  assign process    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || process;

  always_comb begin
    logic signed [32:0] s;
    logic signed [32:0] adj;
    logic               active;
    phase_d = phase_q;
    left_d  = left_q;
    take_d  = take_q;
    pos_d   = pos_q;
    beg_d   = beg_q;
    pend_d  = pend_q;
    nz_d    = nz_q;
    emit    = 1'b0;
    kind_d  = KIND_EMPTY;
    off_d   = '0;
    len_d   = '0;
    active  = 1'b1;
    s       = {start_q[31], start_q};
    adj     = {count_q[31], count_q};

    if (first_q) begin
      // A negative start moves to zero and lengthens the request accordingly.
      if (s < 0) begin
        adj = adj - s;
      end
      pos_d  = '0;
      beg_d  = '0;
      pend_d = '0;
      nz_d   = 1'b0;
      if (adj <= 0) begin
        emit    = 1'b1;
        phase_d = PH_DONE;
        active  = 1'b0;
      end else begin
        take_d = adj[31:0];
        if (s <= 0) begin
          phase_d = PH_TAKE;
          left_d  = adj[31:0];
        end else begin
          phase_d = PH_SKIP;
          left_d  = start_q[31:0];
        end
      end
    end

    if (active && phase_d != PH_DONE) begin
      pos_d = pos_d + 1'b1;
      if (pend_d == 2'd0) begin
        // Lead byte: length from the top bits, payload bits checked for a zero value.
        if (!byte_q[7]) begin
          pend_d = 2'd0;
          nz_d   = |byte_q;
        end else if (byte_q[7:5] == 3'b110) begin
          pend_d = 2'd1;
          nz_d   = |byte_q[4:0];
        end else if (byte_q[7:4] == 4'b1110) begin
          pend_d = 2'd2;
          nz_d   = |byte_q[3:0];
        end else begin
          pend_d = 2'd3;
          nz_d   = |byte_q[2:0];
        end
      end else begin
        if (|byte_q[5:0]) begin
          nz_d = 1'b1;
        end
        pend_d = pend_d - 2'd1;
      end

      if (pend_d == 2'd0) begin
        if (phase_d == PH_SKIP) begin
          if (!nz_d) begin
            emit    = 1'b1;
            phase_d = PH_DONE;
          end else if (left_d == 32'd1) begin
            left_d  = take_d;
            beg_d   = pos_d;
            phase_d = PH_TAKE;
          end else begin
            left_d = left_d - 32'd1;
          end
        end else begin
          if (!nz_d) begin
            emit    = 1'b1;
            phase_d = PH_DONE;
            kind_d  = KIND_TO_END;
            off_d   = to_out(beg_d);
          end else if (left_d == 32'd1) begin
            left_d  = 32'd0;
            emit    = 1'b1;
            phase_d = PH_DONE;
            kind_d  = KIND_RANGE;
            off_d   = to_out(beg_d);
            len_d   = to_out(pos_d - beg_d);
          end else begin
            left_d = left_d - 32'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (process) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q  <= in_i.string_byte;
      first_q <= in_i.first_of_string;
      start_q <= in_i.start_index;
      count_q <= in_i.codepoint_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      left_q  <= '0;
      take_q  <= '0;
      pos_q   <= '0;
      beg_q   <= '0;
      pend_q  <= '0;
      nz_q    <= 1'b0;
    end else if (process) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      take_q  <= take_d;
      pos_q   <= pos_d;
      beg_q   <= beg_d;
      pend_q  <= pend_d;
      nz_q    <= nz_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= process && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && emit) begin
      kind_q <= kind_d;
      off_q  <= off_d;
      len_q  <= len_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = kind_q;
  assign out_o.byte_offset = off_q;
  assign out_o.byte_length = len_q;

`include "utf8_codepoint_substring_locator_assert.svh"

  `UCSL_ASSERT_NEXT(a_emit_ends_string, process && emit, out_valid_q && phase_q == PH_DONE)
  `UCSL_ASSERT_IMPL(a_len_only_range, out_valid_q && kind_q != KIND_RANGE, len_q == '0)
  `UCSL_ASSERT_IMPL(a_done_no_pending, phase_q == PH_DONE, pend_q == 2'd0)
  `UCSL_ASSERT_IMPL(a_hold_when_full, in_valid_q && !out_free, !in_i.ready)

endmodule
